/* rtl/decimal_duration_to_microseconds_defines.svh */
// Assertion macros used by dd2us_final in the decimal duration to microseconds RTL.
// Has no dependencies. Include by bare file name.
`ifndef DECIMAL_DURATION_TO_MICROSECONDS_DEFINES_SVH
`define DECIMAL_DURATION_TO_MICROSECONDS_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define DD2US_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dd2us same-cycle check failed");

// Next-cycle implication, disabled while reset is held
`define DD2US_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dd2us next-cycle check failed");

`endif

/* rtl/dd2us_pkg.sv */
// Package for the decimal duration to microseconds block: widths, character
// and status codes, item and snapshot structs, fraction weight function.
// No dependencies.
package dd2us_pkg;

    localparam int CHAR_W      = 8;
    localparam int DUR_W       = 63;
    localparam int STATUS_W    = 3;
    localparam int FRAC_DIGITS = 6;
    localparam int FRAC_W      = $clog2(10 ** FRAC_DIGITS);
    localparam int CNT_W       = $clog2(FRAC_DIGITS + 1);
    localparam int EXT_W       = DUR_W + 4;
    localparam int DIGIT_W     = 4;
    localparam int SCALE_W     = FRAC_W + DIGIT_W;

    // One second in output units
    localparam logic [FRAC_W-1:0] SCALE = FRAC_W'(10 ** FRAC_DIGITS);

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NEGATIVE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_INT    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_INT   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_INT_OVF   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_BAD_FRAC  = 3'd6;
    localparam logic [STATUS_W-1:0] ST_FINAL_OVF = 3'd7;

    typedef enum logic [2:0] {
        PH_FIRST = 3'b001,
        PH_INT   = 3'b010,
        PH_FRAC  = 3'b100
    } phase_t;

    typedef enum logic [1:0] {
        EE_NONE  = 2'd0,
        EE_MINUS = 2'd1,
        EE_NOINT = 2'd2
    } early_err_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
        logic              no_char;
    } item_t;

    // Per-string results handed from the scanner to the output stage
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DUR_W-1:0]    us;
        logic                us_ovf;
        logic [FRAC_W-1:0]   frac;
    } snap_t;

    // Weight of the fraction digit at position cnt: 10^(FRAC_DIGITS-1-cnt)
    function automatic logic [FRAC_W-1:0] frac_weight(input logic [CNT_W-1:0] cnt);
        logic [FRAC_W-1:0] w;
        w = FRAC_W'(1);
        for (int i = 0; i < FRAC_DIGITS - 1; i++) begin
            if (int'(cnt) + i < FRAC_DIGITS - 1) begin
                w = FRAC_W'(w * 10);
            end
        end
        return w;
    endfunction

endpackage

/* rtl/dd2us_scan.sv */
// Character scanner: integer/fraction accumulators, error flags and the
// end-of-string snapshot register. Depends on dd2us_pkg.
module dd2us_scan
    import dd2us_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  item_en,
    input  item_t item,
    input  logic  snap_take,
    output logic  snap_valid,
    output snap_t snap
);

    logic [DUR_W-1:0]  sec_reg, sec_next;
    logic [DUR_W-1:0]  us_reg, us_next;
    logic              us_ovf_reg, us_ovf_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    phase_t            phase_reg, phase_next;
    early_err_t        ee_reg, ee_next;
    logic              bad_int_reg, bad_int_next;
    logic              int_ovf_reg, int_ovf_next;
    logic              bad_frac_reg, bad_frac_next;
    logic              snap_valid_reg, snap_valid_next;
    snap_t             snap_reg;

    logic               is_digit;
    logic [DIGIT_W-1:0] digit;
    logic [EXT_W-1:0]   sec_prod;
    logic [EXT_W-1:0]   us_prod;
    logic [SCALE_W-1:0] digit_scaled;
    logic [FRAC_W-1:0]  frac_term;
    logic               do_int;
    logic               do_frac;
    logic [STATUS_W-1:0] status_pre;

    // Decode the character and form the shift-add updates
    assign is_digit     = item.char_code inside {[CH_ZERO:CH_NINE]};
    assign digit        = item.char_code[DIGIT_W-1:0];
    assign sec_prod     = ({4'b0, sec_reg} << 3) + ({4'b0, sec_reg} << 1) + EXT_W'(digit);
    assign digit_scaled = SCALE_W'(digit) * SCALE_W'(SCALE);
    assign us_prod      = ({4'b0, us_reg} << 3) + ({4'b0, us_reg} << 1)
                          + EXT_W'(digit_scaled);
    assign frac_term    = FRAC_W'(digit) * frac_weight(cnt_reg);

    // Route the character to the integer or fraction path
    always_comb begin
        phase_next = phase_reg;
        ee_next    = ee_reg;
        do_int     = 1'b0;
        do_frac    = 1'b0;
        if (item_en && !item.no_char) begin
            case (phase_reg)
                PH_FIRST: begin
                    phase_next = PH_INT;
                    if (item.char_code == CH_MINUS) begin
                        ee_next = EE_MINUS;
                    end else if (item.char_code == CH_POINT) begin
                        ee_next = EE_NOINT;
                    end else begin
                        do_int = 1'b1;
                    end
                end
                PH_INT: begin
                    if (ee_reg == EE_NONE) begin
                        if (item.char_code == CH_POINT) begin
                            phase_next = PH_FRAC;
                        end else begin
                            do_int = 1'b1;
                        end
                    end
                end
                PH_FRAC: begin
                    do_frac = (ee_reg == EE_NONE);
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Apply integer and fraction digit updates
    always_comb begin
        sec_next      = sec_reg;
        us_next       = us_reg;
        us_ovf_next   = us_ovf_reg;
        frac_next     = frac_reg;
        cnt_next      = cnt_reg;
        bad_int_next  = bad_int_reg;
        int_ovf_next  = int_ovf_reg;
        bad_frac_next = bad_frac_reg;
        if (do_int) begin
            if (!is_digit) begin
                bad_int_next = 1'b1;
            end else if (!bad_int_reg && !int_ovf_reg) begin
                if (sec_prod[EXT_W-1:DUR_W] != '0) begin
                    int_ovf_next = 1'b1;
                end else begin
                    sec_next    = sec_prod[DUR_W-1:0];
                    us_next     = us_prod[DUR_W-1:0];
                    us_ovf_next = us_ovf_reg || (us_prod[EXT_W-1:DUR_W] != '0);
                end
            end
        end
        if (do_frac) begin
            if (!is_digit) begin
                bad_frac_next = 1'b1;
            end else if (cnt_reg < CNT_W'(FRAC_DIGITS)) begin
                frac_next = frac_reg + frac_term;
                cnt_next  = cnt_reg + CNT_W'(1);
            end
        end
    end

    // Resolve the early status by priority
    always_comb begin
        if (phase_next == PH_FIRST) begin
            status_pre = ST_EMPTY;
        end else if (ee_next == EE_MINUS) begin
            status_pre = ST_NEGATIVE;
        end else if (ee_next == EE_NOINT) begin
            status_pre = ST_NO_INT;
        end else if (bad_int_next) begin
            status_pre = ST_BAD_INT;
        end else if (int_ovf_next) begin
            status_pre = ST_INT_OVF;
        end else if (bad_frac_next) begin
            status_pre = ST_BAD_FRAC;
        end else begin
            status_pre = ST_OK;
        end
    end

    assign snap_valid_next = (item_en && item.last) ? 1'b1
                           : (snap_take ? 1'b0 : snap_valid_reg);

    // Advance the scanner; clear it after the final transfer of a string
    always_ff @(posedge aclk) begin
        if (!aresetn || (item_en && item.last)) begin
            sec_reg      <= '0;
            us_reg       <= '0;
            us_ovf_reg   <= 1'b0;
            frac_reg     <= '0;
            cnt_reg      <= '0;
            phase_reg    <= PH_FIRST;
            ee_reg       <= EE_NONE;
            bad_int_reg  <= 1'b0;
            int_ovf_reg  <= 1'b0;
            bad_frac_reg <= 1'b0;
        end else begin
            sec_reg      <= sec_next;
            us_reg       <= us_next;
            us_ovf_reg   <= us_ovf_next;
            frac_reg     <= frac_next;
            cnt_reg      <= cnt_next;
            phase_reg    <= phase_next;
            ee_reg       <= ee_next;
            bad_int_reg  <= bad_int_next;
            int_ovf_reg  <= int_ovf_next;
            bad_frac_reg <= bad_frac_next;
        end
    end

    // Hold the snapshot until the output stage takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
        end else begin
            snap_valid_reg <= snap_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_en && item.last) begin
            snap_reg <= '{status: status_pre, us: us_next, us_ovf: us_ovf_next,
                          frac: frac_next};
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

endmodule

/* rtl/dd2us_final.sv */
// Output stage: adds the scaled seconds and the padded fraction, decides
// the conversion overflow and holds the result register. Depends on dd2us_pkg and the defines header.
`include "decimal_duration_to_microseconds_defines.svh"
module dd2us_final
    import dd2us_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                snap_take,
    input  snap_t               snap,
    output logic                out_ready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [DUR_W-1:0]    m_duration,
    output logic [STATUS_W-1:0] m_status
);

    logic                m_valid_reg, m_valid_next;
    logic [DUR_W-1:0]    duration_reg;
    logic [STATUS_W-1:0] status_reg;

    logic [DUR_W:0]      total;
    logic [STATUS_W-1:0] status_final;
    logic [DUR_W-1:0]    duration_final;

    // Combine seconds and fraction, flag a sum beyond the output range
    assign total = {1'b0, snap.us} + (DUR_W+1)'(snap.frac);

    always_comb begin
        status_final   = snap.status;
        duration_final = '0;
        if (snap.status == ST_OK) begin
            if (snap.us_ovf || total[DUR_W]) begin
                status_final = ST_FINAL_OVF;
            end else begin
                duration_final = total[DUR_W-1:0];
            end
        end
    end

    assign out_ready    = !m_valid_reg || m_tready;
    assign m_valid_next = snap_take ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Load the result register when the snapshot moves over
    always_ff @(posedge aclk) begin
        if (snap_take) begin
            duration_reg <= duration_final;
            status_reg   <= status_final;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_duration = duration_reg;
    assign m_status   = status_reg;

    `DD2US_ASSERT_IMPL(a_err_zero, aclk, aresetn, m_valid_reg && (status_reg != ST_OK), duration_reg == '0)
    `DD2US_ASSERT_NEXT(a_take_valid, aclk, aresetn, snap_take, m_valid_reg)
    `DD2US_ASSERT_NEXT(a_early_kept, aclk, aresetn, snap_take && (snap.status != ST_OK), status_reg == $past(snap.status))
    `DD2US_ASSERT_IMPL(a_no_early_ovf, aclk, aresetn, snap_take, snap.status != ST_FINAL_OVF)

endmodule

/* rtl/decimal_duration_to_microseconds.sv */
// Top level of the decimal duration to microseconds converter: input
// register and stage handshake around dd2us_scan and dd2us_final.
// Depends on dd2us_pkg.
//
// Usage:
//   s_axis carries one ASCII character per transfer in tdata; tlast marks the
//   final transfer of a string, and tuser set means the transfer carries no
//   character (with tlast alone it denotes an empty string).
//   m_axis carries one result per string: tdata holds the duration in
//   microseconds (zero on any error), tuser holds the status code.
//   Throughput: one character per cycle, also from the last character of one
//   string to the first of the next, while no final character waits on a held snapshot.
//   From the transfer of its final character, the result of a string passes
//   the input register, the snapshot register and then the result register.
//   The scaled seconds are kept by a shift-add beside the integer seconds,
//   so the end of a string needs only one 64-bit add and compare.
//   Stall: a waiting result does not block input; characters keep flowing
//   into the scanner, and s_axis_tready drops only when a further final
//   character would need the occupied snapshot and result registers.
//   Reset: aresetn low for one clock empties all stages and clears the
//   accumulators; the next character starts a new string.
module decimal_duration_to_microseconds
    import dd2us_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,   // end_of_string
    input  logic        s_axis_tuser,   // [0] no_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [62:0] duration_us, [63] zero
    output logic [2:0]  m_axis_tuser    // [2:0] status
);

    logic  in_valid_reg, in_valid_next;
    item_t in_item_reg;

    logic  snap_valid;
    snap_t snap;
    logic  snap_take;
    logic  out_ready;
    logic  snap_hold;
    logic  item_adv;
    logic  s_transfer;

    logic [DUR_W-1:0] m_duration;

    // Stage handshake: a final character waits only for a blocked snapshot
    assign snap_take     = snap_valid && out_ready;
    assign snap_hold     = snap_valid && !out_ready;
    assign item_adv      = in_valid_reg && (!in_item_reg.last || !snap_hold);
    assign s_axis_tready = !in_valid_reg || item_adv;
    assign s_transfer    = s_axis_tvalid && s_axis_tready;
    assign in_valid_next = s_transfer ? 1'b1 : (item_adv ? 1'b0 : in_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Capture the input transfer
    always_ff @(posedge aclk) begin
        if (s_transfer) begin
            in_item_reg <= '{char_code: s_axis_tdata, last: s_axis_tlast,
                             no_char: s_axis_tuser};
        end
    end

    dd2us_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_en    (item_adv),
        .item       (in_item_reg),
        .snap_take  (snap_take),
        .snap_valid (snap_valid),
        .snap       (snap)
    );

    dd2us_final u_final (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .snap_take  (snap_take),
        .snap       (snap),
        .out_ready  (out_ready),
        .m_tvalid   (m_axis_tvalid),
        .m_tready   (m_axis_tready),
        .m_duration (m_duration),
        .m_status   (m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, m_duration};

endmodule
